// File: rtl/bprg_pkg.sv
// shared types and constants of the bit-plane run-length gamma packer
`timescale 1ns / 1ps
`default_nettype none

package bprg_pkg;

  localparam int CNT_W       = 21;
  localparam int POS_W       = 5;
  localparam int LEN_W       = 22;
  localparam int RES_W       = 5;
  localparam int MAX_RESULTS = 26;

  localparam logic [1:0] MODE_RAW     = 2'd0;
  localparam logic [1:0] MODE_RLE     = 2'd1;
  localparam logic [1:0] MODE_MEASURE = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  typedef enum logic [1:0] {
    LEAD_NONE,
    LEAD_BIT,
    LEAD_GAMMA
  } lead_t;

  typedef struct packed {
    logic [1:0]       mode;
    lead_t            lead;
    logic             lead_val;
    logic [CNT_W-1:0] lead_cnt;
    logic             last;
    logic [CNT_W-1:0] tail_cnt;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] bit_length;
    logic             used_compression;
    logic             byte_valid;
    logic             last_result;
  } result_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_BIT,
    S_GZERO,
    S_GBITS,
    S_FLUSH,
    S_PAD,
    S_MEAS
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/bprg_fifo.sv
// small show-ahead queue
`timescale 1ns / 1ps
`default_nettype none

module bprg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bprg_front.sv
// front end: mode register, run tracker and command generation
`timescale 1ns / 1ps
`default_nettype none

module bprg_front #(
  parameter int MAX_PIXELS = 1048576
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    compression_mode,
  input  wire logic          pixel,
  input  wire logic          last_pixel,
  input  wire logic          push,
  output logic               full,
  output logic               cmd_push,
  output bprg_pkg::cmd_t     cmd,
  input  wire logic          cmd_full
);

  localparam logic [bprg_pkg::CNT_W-1:0] RUN_MAX = bprg_pkg::CNT_W'(MAX_PIXELS);

  logic [1:0]                 mode;
  logic                       run_value;
  logic                       run_value_next;
  logic [bprg_pkg::CNT_W-1:0] run_length;
  logic [bprg_pkg::CNT_W-1:0] run_length_next;
  logic                       first_pending;
  logic                       first_pending_next;
  logic                       rle;
  logic                       accept;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;
  assign accept    = push && !cmd_full;
  assign cmd_push  = accept;
  assign rle       = (mode != bprg_pkg::MODE_RAW);

  always_comb begin
    cmd.mode           = mode;
    cmd.lead           = bprg_pkg::LEAD_NONE;
    cmd.lead_val       = pixel;
    cmd.lead_cnt       = run_length;
    cmd.last           = last_pixel;
    run_value_next     = run_value;
    run_length_next    = run_length;
    first_pending_next = first_pending;
    if (first_pending) begin
      if (rle) begin
        cmd.lead = bprg_pkg::LEAD_BIT;
      end
      run_value_next     = pixel;
      run_length_next    = bprg_pkg::CNT_W'(1);
      first_pending_next = 1'b0;
    end else if (pixel == run_value) begin
      if (run_length < RUN_MAX) begin
        run_length_next = run_length + 1'b1;
      end
    end else begin
      if (rle) begin
        cmd.lead = bprg_pkg::LEAD_GAMMA;
      end
      run_value_next  = pixel;
      run_length_next = bprg_pkg::CNT_W'(1);
    end
    if (!rle) begin
      cmd.lead = bprg_pkg::LEAD_BIT;
    end
    cmd.tail_cnt = run_length_next;
    if (last_pixel) begin
      run_value_next     = 1'b0;
      run_length_next    = '0;
      first_pending_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= bprg_pkg::MODE_RAW;
      run_value     <= 1'b0;
      run_length    <= '0;
      first_pending <= 1'b1;
    end else begin
      if (cfg_valid) begin
        mode <= compression_mode;
      end
      if (accept) begin
        run_value     <= run_value_next;
        run_length    <= run_length_next;
        first_pending <= first_pending_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bprg_back.sv
// back end: bit sequencer, gamma coder, byte packer, flush, block padding and measure result
`timescale 1ns / 1ps
`default_nettype none

module bprg_back #(
  parameter int FRAME_BYTES = 20
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_empty,
  input  wire bprg_pkg::cmd_t cmd_in,
  output logic                cmd_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output bprg_pkg::result_t   res
);

  localparam int BCC_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [BCC_W-1:0] BCC_LAST = BCC_W'(FRAME_BYTES - 1);
  localparam logic [bprg_pkg::RES_W-1:0] RES_MAX = bprg_pkg::RES_W'(bprg_pkg::MAX_RESULTS);

  function automatic logic [bprg_pkg::POS_W-1:0] msb_index(
    input logic [bprg_pkg::CNT_W-1:0] v
  );
    logic [bprg_pkg::POS_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < bprg_pkg::CNT_W; i++) begin
      if (v[i]) begin
        idx = bprg_pkg::POS_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic is_rle(input logic [1:0] m);
    return m != bprg_pkg::MODE_RAW;
  endfunction

  function automatic logic is_measure(input logic [1:0] m);
    return (m == bprg_pkg::MODE_MEASURE) || (m == bprg_pkg::MODE_SPARE);
  endfunction

  bprg_pkg::back_state_t      state;
  bprg_pkg::back_state_t      state_next;
  bprg_pkg::cmd_t             cmd;
  bprg_pkg::cmd_t             cmd_next;
  bprg_pkg::cmd_t             cv;
  logic                       tail;
  logic                       tail_next;
  logic [bprg_pkg::CNT_W-1:0] gcnt;
  logic [bprg_pkg::CNT_W-1:0] gcnt_next;
  logic [bprg_pkg::POS_W-1:0] gpos;
  logic [bprg_pkg::POS_W-1:0] gpos_next;
  logic [bprg_pkg::POS_W-1:0] gzero;
  logic [bprg_pkg::POS_W-1:0] gzero_next;
  logic [7:0]                 partial;
  logic [7:0]                 partial_next;
  logic [2:0]                 bitpos;
  logic [2:0]                 bitpos_next;
  logic [bprg_pkg::LEN_W-1:0] total;
  logic [bprg_pkg::LEN_W-1:0] total_next;
  logic [BCC_W-1:0]           bcc;
  logic [BCC_W-1:0]           bcc_next;
  logic [BCC_W-1:0]           bcc_after;
  logic [bprg_pkg::RES_W-1:0] idx;
  logic [bprg_pkg::RES_W-1:0] idx_next;

  logic                       go;
  logic                       after_lead;
  logic                       gamma_start;
  logic [bprg_pkg::CNT_W-1:0] gsrc;
  logic [bprg_pkg::CNT_W-1:0] gval;
  logic [bprg_pkg::POS_W-1:0] gmsb;
  logic                       emit_en;
  logic                       emit_val;
  logic                       final_bit;
  logic                       push_req;
  logic                       push_byte;
  logic                       push_last;
  logic                       final_stage;
  logic [7:0]                 push_data;
  logic [bprg_pkg::LEN_W-1:0] push_len;
  logic                       end_step;
  logic [7:0]                 partial_set;

  assign go        = !res_full;
  assign cv        = (state == bprg_pkg::S_LOAD) ? cmd_in : cmd;
  assign gsrc      = (state == bprg_pkg::S_LOAD && cmd_in.lead == bprg_pkg::LEAD_GAMMA) ?
                     cmd_in.lead_cnt : cv.tail_cnt;
  assign gval      = (gsrc == '0) ? bprg_pkg::CNT_W'(1) : gsrc;
  assign gmsb      = msb_index(gval);
  assign bcc_after = (bcc == BCC_LAST) ? '0 : bcc + 1'b1;

  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    tail_next    = tail;
    gcnt_next    = gcnt;
    gpos_next    = gpos;
    gzero_next   = gzero;
    partial_next = partial;
    bitpos_next  = bitpos;
    total_next   = total;
    bcc_next     = bcc;
    idx_next     = idx;
    cmd_pop      = 1'b0;
    after_lead   = 1'b0;
    gamma_start  = 1'b0;
    emit_en      = 1'b0;
    emit_val     = 1'b0;
    final_bit    = 1'b0;
    push_req     = 1'b0;
    push_byte    = 1'b0;
    push_last    = 1'b0;
    final_stage  = 1'b0;
    push_data    = '0;
    push_len     = total;
    end_step     = 1'b0;
    partial_set  = partial;

    case (state)
      bprg_pkg::S_LOAD: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          cmd_next  = cmd_in;
          idx_next  = '0;
          tail_next = 1'b0;
          case (cmd_in.lead)
            bprg_pkg::LEAD_BIT:   state_next = bprg_pkg::S_BIT;
            bprg_pkg::LEAD_GAMMA: gamma_start = 1'b1;
            default:              after_lead = 1'b1;
          endcase
        end
      end
      bprg_pkg::S_BIT: begin
        if (go) begin
          emit_en    = 1'b1;
          emit_val   = cmd.lead_val;
          final_bit  = cmd.last && !is_rle(cmd.mode);
          after_lead = 1'b1;
        end
      end
      bprg_pkg::S_GZERO: begin
        if (go) begin
          emit_en    = 1'b1;
          emit_val   = 1'b0;
          gzero_next = gzero - 1'b1;
          if (gzero == bprg_pkg::POS_W'(1)) begin
            state_next = bprg_pkg::S_GBITS;
          end
        end
      end
      bprg_pkg::S_GBITS: begin
        if (go) begin
          emit_en   = 1'b1;
          emit_val  = gcnt[gpos];
          gpos_next = gpos - 1'b1;
          if (gpos == '0) begin
            if (tail) begin
              final_bit  = 1'b1;
              state_next = is_measure(cmd.mode) ? bprg_pkg::S_MEAS : bprg_pkg::S_FLUSH;
            end else begin
              after_lead = 1'b1;
            end
          end
        end
      end
      bprg_pkg::S_FLUSH: begin
        if (go) begin
          if (bitpos != '0) begin
            push_req     = 1'b1;
            push_byte    = 1'b1;
            final_stage  = 1'b1;
            push_data    = partial;
            partial_next = '0;
            bitpos_next  = '0;
          end
          state_next = bprg_pkg::S_PAD;
        end
      end
      bprg_pkg::S_PAD: begin
        if (go) begin
          if (bcc != '0 && idx < RES_MAX) begin
            push_req    = 1'b1;
            push_byte   = 1'b1;
            final_stage = 1'b1;
          end else begin
            end_step   = 1'b1;
            state_next = bprg_pkg::S_LOAD;
          end
        end
      end
      bprg_pkg::S_MEAS: begin
        if (go) begin
          push_req   = 1'b1;
          push_last  = 1'b1;
          end_step   = 1'b1;
          state_next = bprg_pkg::S_LOAD;
        end
      end
      default: state_next = bprg_pkg::S_LOAD;
    endcase

    if (after_lead) begin
      if (!cv.last) begin
        state_next = bprg_pkg::S_LOAD;
      end else if (is_rle(cv.mode)) begin
        tail_next   = 1'b1;
        gamma_start = 1'b1;
      end else begin
        state_next = bprg_pkg::S_FLUSH;
      end
    end

    if (gamma_start) begin
      gcnt_next  = gval;
      gpos_next  = gmsb;
      gzero_next = gmsb;
      state_next = (gmsb == '0) ? bprg_pkg::S_GBITS : bprg_pkg::S_GZERO;
    end

    // one coded bit: counted, and outside measure mode placed into the partial byte
    if (emit_en) begin
      total_next = (total == '1) ? total : total + 1'b1;
      if (!is_measure(cmd.mode)) begin
        partial_set[3'd7 - bitpos] = partial[3'd7 - bitpos] | emit_val;
        if (bitpos == 3'd7) begin
          push_req     = 1'b1;
          push_byte    = 1'b1;
          final_stage  = final_bit;
          push_data    = partial_set;
          push_len     = total_next;
          partial_next = '0;
          bitpos_next  = '0;
        end else begin
          partial_next = partial_set;
          bitpos_next  = bitpos + 1'b1;
        end
      end
    end

    if (push_req && push_byte) begin
      bcc_next = bcc_after;
    end
    if (push_req && idx < RES_MAX) begin
      idx_next = idx + 1'b1;
    end

    if (end_step) begin
      partial_next = '0;
      bitpos_next  = '0;
      total_next   = '0;
      bcc_next     = '0;
    end
  end

  assign res_push             = push_req && (idx < RES_MAX);
  assign res.out_byte         = push_data;
  assign res.bit_length       = push_len;
  assign res.used_compression = is_rle(cmd.mode);
  assign res.byte_valid       = push_byte;
  assign res.last_result      = push_last ||
                                (final_stage && (bcc_after == '0 || idx == RES_MAX - 1'b1));

  always_ff @(posedge clk) begin
    cmd   <= cmd_next;
    gcnt  <= gcnt_next;
    gpos  <= gpos_next;
    gzero <= gzero_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bprg_pkg::S_LOAD;
      tail    <= 1'b0;
      partial <= '0;
      bitpos  <= '0;
      total   <= '0;
      bcc     <= '0;
      idx     <= '0;
    end else begin
      state   <= state_next;
      tail    <= tail_next;
      partial <= partial_next;
      bitpos  <= bitpos_next;
      total   <= total_next;
      bcc     <= bcc_next;
      idx     <= idx_next;
    end
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last_result) |=> (bitpos == '0 && !res_push))
    else $error("result after final result of image");

  a_length_only: assert property (@(posedge clk) disable iff (rst)
    (res_push && !res.byte_valid) |-> (state == bprg_pkg::S_MEAS && res.last_result))
    else $error("length-only result outside measure finish");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    idx <= RES_MAX)
    else $error("per-item result count over limit");

endmodule

`default_nettype wire

// File: rtl/bitplane_run_length_gamma_packer.sv
// top level of the bit-plane run-length gamma packer
// each item is written to the command queue; the back end loads one command when idle,
// then emits its coded bits, one per cycle while the result queue has room;
// a run of n takes 2*bits(n)-1 bits; items continuing a run in rle or measure mode emit none
// last pixel: flush, zero padding to the frame end, closing step (measure: length result)
// reset clears the mode register, the run tracker, both queues and the packer state at once
`timescale 1ns / 1ps
`default_nettype none

module bitplane_run_length_gamma_packer #(
  parameter int FRAME_BYTES = 20,
  parameter int MAX_PIXELS  = 1048576,
  parameter int CMD_DEPTH   = 4,
  parameter int OUT_DEPTH   = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  compression_mode,
  input  wire logic        pixel,
  input  wire logic        last_pixel,
  input  wire logic        push,
  output logic             full,
  output logic [7:0]       out_byte,
  output logic [21:0]      bit_length,
  output logic             used_compression,
  output logic             byte_valid,
  output logic             last_result,
  output logic             empty,
  input  wire logic        pop
);

  localparam int CMD_W = $bits(bprg_pkg::cmd_t);
  localparam int RES_W = $bits(bprg_pkg::result_t);

  bprg_pkg::cmd_t    front_cmd;
  bprg_pkg::cmd_t    back_cmd;
  bprg_pkg::result_t back_res;
  bprg_pkg::result_t out_res;
  logic              cmd_push;
  logic              cmd_full;
  logic              cmd_pop;
  logic              cmd_empty;
  logic              res_push;
  logic              res_full;

  bprg_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .compression_mode(compression_mode),
    .pixel           (pixel),
    .last_pixel      (last_pixel),
    .push            (push),
    .full            (full),
    .cmd_push        (cmd_push),
    .cmd             (front_cmd),
    .cmd_full        (cmd_full)
  );

  bprg_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (cmd_push),
    .wr_data(front_cmd),
    .full   (cmd_full),
    .rd     (cmd_pop),
    .rd_data(back_cmd),
    .empty  (cmd_empty)
  );

  bprg_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd_in   (back_cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  bprg_fifo #(
    .WIDTH(RES_W),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (res_push),
    .wr_data(back_res),
    .full   (res_full),
    .rd     (pop),
    .rd_data(out_res),
    .empty  (empty)
  );

  assign out_byte         = out_res.out_byte;
  assign bit_length       = out_res.bit_length;
  assign used_compression = out_res.used_compression;
  assign byte_valid       = out_res.byte_valid;
  assign last_result      = out_res.last_result;

endmodule

`default_nettype wire

// File: sim/bitplane_run_length_gamma_packer_tb.sv
// testbench for the bit-plane run-length gamma packer: directed and random images with a predictor
`timescale 1ns / 1ps

module bitplane_run_length_gamma_packer_tb;

  localparam int FRAME_BYTES = 20;
  localparam int MAX_PIXELS  = 1048576;
  localparam int SETTLE      = 100;
  localparam logic [21:0] LEN_SAT = 22'h3FFFFF;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  compression_mode;
  logic        pixel;
  logic        last_pixel;
  logic        push;
  logic        full;
  logic [7:0]  out_byte;
  logic [21:0] bit_length;
  logic        used_compression;
  logic        byte_valid;
  logic        last_result;
  logic        empty;
  logic        pop;

  bitplane_run_length_gamma_packer uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .compression_mode (compression_mode),
    .pixel            (pixel),
    .last_pixel       (last_pixel),
    .push             (push),
    .full             (full),
    .out_byte         (out_byte),
    .bit_length       (bit_length),
    .used_compression (used_compression),
    .byte_valid       (byte_valid),
    .last_result      (last_result),
    .empty            (empty),
    .pop              (pop)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [1:0]                 mode_reg;
  logic [7:0]                 pk_byte;
  logic [2:0]                 bit_pos;
  logic                       run_val;
  logic [bprg_pkg::CNT_W-1:0] run_len;
  logic                       first_pend;
  logic [bprg_pkg::LEN_W-1:0] total_bits;
  logic [4:0]                 blk_cnt;
  logic                       measuring;
  logic                       comp_flag;

  bprg_pkg::result_t step_out[$];
  bprg_pkg::result_t predicted_out[$];

  int  mismatches = 0;
  int  rx_hold = 0;
  bit  rx_fast = 1'b0;
  bit  tx_fast = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function void put_out(input logic [7:0] b, input logic valid);
    bprg_pkg::result_t r;
    if (step_out.size() >= bprg_pkg::MAX_RESULTS) return;
    r.out_byte         = b;
    r.bit_length       = total_bits;
    r.used_compression = comp_flag;
    r.byte_valid       = valid;
    r.last_result      = 1'b0;
    step_out.push_back(r);
  endfunction

  function void emit_byte(input logic [7:0] b);
    put_out(b, 1'b1);
    blk_cnt = blk_cnt + 5'd1;
    if (blk_cnt >= 5'(FRAME_BYTES)) blk_cnt = '0;
  endfunction

  function void emit_bit(input logic b);
    if (total_bits < LEN_SAT) total_bits = total_bits + 22'd1;
    if (measuring) return;
    if (b) pk_byte[3'd7 - bit_pos] = 1'b1;
    if (bit_pos == 3'd7) begin
      emit_byte(pk_byte);
      pk_byte = '0;
      bit_pos = '0;
    end else begin
      bit_pos = bit_pos + 3'd1;
    end
  endfunction

  function void emit_gamma(input logic [bprg_pkg::CNT_W-1:0] count);
    logic [bprg_pkg::CNT_W-1:0] v;
    int n;
    int i;
    if (count == '0) count = bprg_pkg::CNT_W'(1);
    n = 0;
    for (v = count; v != '0; v = v >> 1) n++;
    for (i = 1; i < n; i++) emit_bit(1'b0);
    for (i = n; i > 0; i--) emit_bit(count[i-1]);
  endfunction

  function void clear_stream();
    pk_byte    = '0;
    bit_pos    = '0;
    run_val    = 1'b0;
    run_len    = '0;
    first_pend = 1'b1;
    total_bits = '0;
    blk_cnt    = '0;
  endfunction

  function void pack_pixel(input logic pix, input logic lst);
    logic rle;
    rle       = (mode_reg != bprg_pkg::MODE_RAW);
    measuring = (mode_reg == bprg_pkg::MODE_MEASURE) || (mode_reg == bprg_pkg::MODE_SPARE);
    comp_flag = rle;
    step_out.delete();
    if (first_pend) begin
      if (rle) emit_bit(pix);
      run_val    = pix;
      run_len    = bprg_pkg::CNT_W'(1);
      first_pend = 1'b0;
    end else if (pix == run_val) begin
      if (run_len < bprg_pkg::CNT_W'(MAX_PIXELS)) run_len = run_len + 1'b1;
    end else begin
      if (rle) emit_gamma(run_len);
      run_val = pix;
      run_len = bprg_pkg::CNT_W'(1);
    end
    if (!rle) emit_bit(pix);
    if (lst) begin
      if (rle) emit_gamma(run_len);
      if (measuring) begin
        put_out(8'h00, 1'b0);
      end else begin
        if (bit_pos != '0) begin
          emit_byte(pk_byte);
          pk_byte = '0;
          bit_pos = '0;
        end
        while (blk_cnt != '0 && step_out.size() < bprg_pkg::MAX_RESULTS) emit_byte(8'h00);
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last_result = 1'b1;
      clear_stream();
    end
    foreach (step_out[k]) predicted_out.push_back(step_out[k]);
  endfunction

  function int gap_draw();
    return tx_fast ? 0 : $urandom_range(0, 15);
  endfunction

  // one pixel item; push stays high on return so back-to-back items need no gap
  task automatic send_pixel(input logic p, input logic l, input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    pixel      <= p;
    last_pixel <= l;
    do @(posedge clk); while (full);
    pack_pixel(p, l);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (predicted_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_drained();
    cfg_valid        <= 1'b1;
    compression_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_reg = m;
  endtask

  // n pixels msb first, last marked on the final one
  task automatic send_pattern(input logic [31:0] bits, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) send_pixel(bits[i], i == 0, gap_draw());
  endtask

  task automatic send_image(input int len, input bit noise, input int split_at);
    int  i;
    int  run_left;
    logic cur;
    logic p;
    run_left = 0;
    cur = 1'($urandom_range(0, 1));
    for (i = 0; i < len; i++) begin
      if (i == split_at) set_mode(2'($urandom_range(0, 3)));
      if (noise) begin
        p = 1'($urandom_range(0, 1));
      end else begin
        if (run_left == 0) begin
          cur = ~cur;
          run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 70)
                                                 : $urandom_range(1, 12);
        end
        p = cur;
        run_left--;
      end
      send_pixel(p, i == len - 1, gap_draw());
    end
  endtask

  task automatic test_each_mode();
    set_mode(bprg_pkg::MODE_RAW);
    send_pattern(32'h1, 1);
    send_pattern(32'b0_1010_1011, 9);
    set_mode(bprg_pkg::MODE_RLE);
    send_pattern(32'b0001, 4);
    set_mode(bprg_pkg::MODE_MEASURE);
    send_pattern(32'b110, 3);
    set_mode(bprg_pkg::MODE_SPARE);
    send_pattern(32'b0, 1);
  endtask

  task automatic test_mode_switch();
    set_mode(bprg_pkg::MODE_RLE);
    send_pixel(1'b1, 1'b0, gap_draw());
    send_pixel(1'b1, 1'b0, gap_draw());
    set_mode(bprg_pkg::MODE_RAW);
    send_pixel(1'b0, 1'b0, gap_draw());
    send_pixel(1'b1, 1'b0, gap_draw());
    set_mode(bprg_pkg::MODE_MEASURE);
    send_pixel(1'b1, 1'b1, gap_draw());
  endtask

  task automatic test_backpressure();
    int i;
    set_mode(bprg_pkg::MODE_RAW);
    rx_hold = 400;
    for (i = 0; i < 120; i++) send_pixel(1'($urandom_range(0, 1)), i == 119, 0);
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    int len;
    int images;
    int split;
    sent = 0;
    images = 0;
    while (sent < 290) begin
      if (images == 0) set_mode(bprg_pkg::MODE_RAW);
      else if (images == 1) set_mode(bprg_pkg::MODE_SPARE);
      else if ($urandom_range(0, 1)) set_mode(2'($urandom_range(0, 3)));
      rx_fast = ($urandom_range(0, 3) == 0);
      tx_fast = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      split = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
      send_image(len, $urandom_range(0, 4) == 0, split);
      sent += len;
      images++;
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  // result side: random pop stalls, checks each popped item
  initial begin
    int stall;
    bprg_pkg::result_t want;
    pop <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_fast ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (predicted_out.size() == 0) begin
        report_mismatch("result with nothing predicted");
      end else begin
        want = predicted_out.pop_front();
        if (out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.out_byte));
        if (bit_length !== want.bit_length)
          report_mismatch($sformatf("bit_length %0d, want %0d", bit_length, want.bit_length));
        if (used_compression !== want.used_compression)
          report_mismatch($sformatf("used_compression %b, want %b",
                                    used_compression, want.used_compression));
        if (byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid %b, want %b", byte_valid, want.byte_valid));
        if (last_result !== want.last_result)
          report_mismatch($sformatf("last_result %b, want %b", last_result, want.last_result));
      end
    end
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst              <= 1'b1;
    cfg_valid        <= 1'b0;
    compression_mode <= bprg_pkg::MODE_RAW;
    pixel            <= 1'b0;
    last_pixel       <= 1'b0;
    push             <= 1'b0;
    mode_reg = bprg_pkg::MODE_RAW;
    clear_stream();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_each_mode();
    test_mode_switch();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bprg_pkg.sv
rtl/bprg_fifo.sv
rtl/bprg_front.sv
rtl/bprg_back.sv
rtl/bitplane_run_length_gamma_packer.sv
sim/bitplane_run_length_gamma_packer_tb.sv
